FILE: sv/shgs_pkg.sv
// ----------------------------------------------------------------------------
// shgs_pkg
// Shared types and constants of the spectrum history gate/similarity unit.
// ----------------------------------------------------------------------------
package shgs_pkg;

  localparam int HIST_LEN  = 512;
  localparam int BANDS     = 8;
  localparam int MAX_BANDS = 8;
  localparam int VAL_W     = 16;
  localparam int SLOT_W    = $clog2(HIST_LEN);
  localparam int J_W       = $clog2(HIST_LEN + 1);
  localparam int BAND_W    = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CD_W      = J_W + 12;

  localparam int NUM_W = 54;
  localparam int DEN_W = 38;
  localparam int QUO_W = 17;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SIM_DIV   = 3 * BANDS;
  // reciprocal of SIM_DIV, exact for lag totals below 2^21
  localparam int SIM_SH    = 26;
  localparam int SIM_RECIP = (2 ** SIM_SH + SIM_DIV - 1) / SIM_DIV;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_FRAMES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SCALE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_BASELINE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUDNESS_RESTORE  = 3'd3;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_GATE  = 2'd1;
  localparam logic [1:0] KIND_SIM   = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef logic [BANDS-1:0][VAL_W-1:0] row_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] band_in_0;
    logic [VAL_W-1:0] band_in_1;
    logic [VAL_W-1:0] band_in_2;
    logic [VAL_W-1:0] band_in_3;
    logic [VAL_W-1:0] band_in_4;
    logic [VAL_W-1:0] band_in_5;
    logic [VAL_W-1:0] band_in_6;
    logic [VAL_W-1:0] band_in_7;
    logic [8:0]       lag;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] band_out_0;
    logic [VAL_W-1:0] band_out_1;
    logic [VAL_W-1:0] band_out_2;
    logic [VAL_W-1:0] band_out_3;
    logic [VAL_W-1:0] band_out_4;
    logic [VAL_W-1:0] band_out_5;
    logic [VAL_W-1:0] band_out_6;
    logic [VAL_W-1:0] band_out_7;
    logic [VAL_W-1:0] similarity;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RD_SIM, ST_LOAD_RD, ST_LOAD_WT, ST_OUT,
    ST_G_BAND, ST_W_RD, ST_W_MUL, ST_W_ACC, ST_W_DEN, ST_W_DIV, ST_W_WAIT,
    ST_F_INIT, ST_F_SET, ST_F_RD, ST_F_M1, ST_F_M2, ST_F_CMP,
    ST_C_MUL, ST_C_CUR, ST_C_CMP, ST_C_WAIT, ST_G_NEXT,
    ST_L_CHK, ST_L_BAND, ST_L_DIV, ST_L_WAIT, ST_L_NEXT,
    ST_S_LAG, ST_S_BAND, ST_S_T1, ST_S_W1, ST_S_T2, ST_S_W2, ST_S_SQ,
    ST_S_T3, ST_S_W3, ST_S_NEXT, ST_S_FIN, ST_S_WF
  } state_e;

  function automatic logic [VAL_W-1:0] sat16(input logic [QUO_W:0] v);
    return (v > (QUO_W+1)'(65535)) ? 16'hFFFF : v[VAL_W-1:0];
  endfunction

endpackage

FILE: sv/spectrum_history_gate_similarity_unit.sv
// ----------------------------------------------------------------------------
// spectrum_history_gate_similarity_unit
// Frame history ring with per-band noise gate and lag similarity table.
//
//   channel  direction  handshake          word
//   in       input      valid / stall      in_word_t (kind, bands, lag)
//   out      output     valid / stall      out_word_t (bands, similarity)
//   cfg      input      valid / ready      index + 16-bit data
//
// Store is written straight from idle. Read similarity goes through the
// similarity memory read and the output register. Gate time is set by the
// window walk through the frame memory and the shared divide, and grows with
// the weighted baseline. Similarity time is set by three divides per band.
// No clearing pass after reset: a fill count marks unwritten slots as zero.
// A result waits in the output register; a new item is taken when idle.
// ----------------------------------------------------------------------------
module spectrum_history_gate_similarity_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  shgs_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output shgs_pkg::out_word_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [shgs_pkg::CFG_DAT_W-1:0] cfg_data_i
);

  localparam int VW = shgs_pkg::VAL_W;
  localparam int SW = shgs_pkg::SLOT_W;
  localparam int JW = shgs_pkg::J_W;
  localparam int BW = shgs_pkg::BAND_W;
  localparam int NW = shgs_pkg::NUM_W;
  localparam int DW = shgs_pkg::DEN_W;
  localparam int AW = shgs_pkg::MUL_A_W;
  localparam int MW = shgs_pkg::MUL_B_W;

  shgs_pkg::state_e state_q, state_d;

  logic [SW-1:0] newest_q, newest_d;
  logic [JW-1:0] fill_q, fill_d;
  logic          sim_valid_q, sim_valid_d;

  logic [9:0]  hist_q;
  logic [15:0] scale_q;
  logic        wbase_q, restore_q;

  logic [1:0]                  kind_q, kind_d;
  logic [8:0]                  lag_q, lag_d;
  shgs_pkg::row_t              cur_q, cur_d;
  logic [JW-1:0]               j_q, j_d;
  logic [BW-1:0]               band_q, band_d;
  logic [33:0]                 acc_q, acc_d;
  logic [VW-1:0]               av_q, av_d;
  logic [25:0]                 fn_q, fn_d;
  logic [41:0]                 cn_q, cn_d;
  logic [shgs_pkg::CD_W-1:0]   cd_q, cd_d;
  shgs_pkg::row_t              g_q, g_d;
  logic [18:0]                 suma_q, suma_d, sumb_q, sumb_d;
  logic [20:0]                 total_q, total_d;
  logic [16:0]                 s_q, s_d, d_q, d_d, up_q, up_d;
  logic [35:0]                 sq_q, sq_d;
  logic [VW-1:0]               sim_res_q, sim_res_d;
  shgs_pkg::out_word_t         out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic [AW-1:0]               mul_a;
  logic [MW-1:0]               mul_b;
  logic [shgs_pkg::PROD_W-1:0] prod_q;

  shgs_pkg::row_t frame_mem [shgs_pkg::HIST_LEN];
  logic           rd_en, wr_en;
  logic [SW-1:0]  rd_addr, wr_addr;
  shgs_pkg::row_t wr_row, rdata_q;
  logic           rok_q;

  logic [VW-1:0] sim_mem [shgs_pkg::HIST_LEN];
  logic          sim_rd_en, sim_wr_en;
  logic [SW-1:0] sim_rd_addr, sim_wr_addr;
  logic [VW-1:0] sim_wr_data, sim_rdata_q;

  shgs_pkg::div_req_t div_req;
  shgs_pkg::div_rsp_t div_rsp;

  logic [JW-1:0]  win;
  logic [SW-1:0]  back_slot, next_slot;
  logic [VW-1:0]  h_val, cur_b, g_b;
  logic [VW-1:0]  in_bands [shgs_pkg::MAX_BANDS];
  logic [VW-1:0]  obands [shgs_pkg::MAX_BANDS];
  logic [25:0]    v_sum;
  logic [16:0]    f_sum, f_dif, f_up;
  logic [17:0]    den18;
  logic [18:0]    tri_w;
  logic [36:0]    den37;
  logic [37:0]    curcd;

  shgs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  function automatic logic slot_ok(input logic [SW-1:0] s, input logic [JW-1:0] f);
    if (s == '0) begin
      return f == JW'(shgs_pkg::HIST_LEN);
    end
    return f >= JW'(s);
  endfunction

  assign win = (32'(hist_q) < shgs_pkg::HIST_LEN) ? JW'(hist_q) : JW'(shgs_pkg::HIST_LEN);

  always_comb begin
    logic [SW-1:0] jj;
    jj = j_q[SW-1:0];
    if (newest_q >= jj) begin
      back_slot = newest_q - jj;
    end else begin
      back_slot = SW'(({1'b0, newest_q} + (SW+1)'(shgs_pkg::HIST_LEN)) - {1'b0, jj});
    end
  end

  assign next_slot = (32'(newest_q) == shgs_pkg::HIST_LEN - 1) ? '0 : newest_q + SW'(1);
  assign h_val = rok_q ? rdata_q[band_q] : '0;
  assign cur_b = cur_q[band_q];
  assign g_b   = g_q[band_q];
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != shgs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_bands[0] = in_data_i.band_in_0;
  assign in_bands[1] = in_data_i.band_in_1;
  assign in_bands[2] = in_data_i.band_in_2;
  assign in_bands[3] = in_data_i.band_in_3;
  assign in_bands[4] = in_data_i.band_in_4;
  assign in_bands[5] = in_data_i.band_in_5;
  assign in_bands[6] = in_data_i.band_in_6;
  assign in_bands[7] = in_data_i.band_in_7;

  always_comb begin
    for (int k = 0; k < shgs_pkg::MAX_BANDS; k++) begin
      obands[k] = '0;
    end
    for (int k = 0; k < shgs_pkg::BANDS; k++) begin
      obands[k] = g_q[k];
    end
    for (int k = 0; k < shgs_pkg::BANDS; k++) begin
      wr_row[k] = in_bands[k];
    end
  end

  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    fill_d      = fill_q;
    sim_valid_d = sim_valid_q;
    kind_d      = kind_q;
    lag_d       = lag_q;
    cur_d       = cur_q;
    j_d         = j_q;
    band_d      = band_q;
    acc_d       = acc_q;
    av_d        = av_q;
    fn_d        = fn_q;
    cn_d        = cn_q;
    cd_d        = cd_q;
    g_d         = g_q;
    suma_d      = suma_q;
    sumb_d      = sumb_q;
    total_d     = total_q;
    s_d         = s_q;
    d_d         = d_q;
    up_d        = up_q;
    sq_d        = sq_q;
    sim_res_d   = sim_res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = '0;
    mul_b       = '0;
    rd_en       = 1'b0;
    rd_addr     = back_slot;
    wr_en       = 1'b0;
    wr_addr     = next_slot;
    sim_rd_en   = 1'b0;
    sim_rd_addr = SW'(in_data_i.lag);
    sim_wr_en   = 1'b0;
    sim_wr_addr = j_q[SW-1:0];
    sim_wr_data = shgs_pkg::sat16(prod_q[shgs_pkg::SIM_SH +: 18]);
    div_req     = '0;
    v_sum       = acc_q[25:0] + prod_q[25:0];
    f_sum       = 17'(cur_b) + 17'(h_val);
    f_dif       = (cur_b > h_val) ? 17'(cur_b - h_val) : 17'(h_val - cur_b);
    f_up        = (cur_b > h_val) ? 17'(cur_b - h_val) : '0;
    den18       = '0;
    tri_w       = prod_q[18:0] >> 1;
    den37       = 37'(sq_q) + 37'(prod_q[33:0]);
    curcd       = prod_q[37:0];

    case (state_q)
      shgs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = in_data_i.kind;
          lag_d  = in_data_i.lag;
          case (in_data_i.kind)
            shgs_pkg::KIND_STORE: begin
              wr_en    = 1'b1;
              newest_d = next_slot;
              if (fill_q != JW'(shgs_pkg::HIST_LEN)) begin
                fill_d = fill_q + JW'(1);
              end
            end
            shgs_pkg::KIND_READ: begin
              sim_rd_en = 1'b1;
              state_d   = shgs_pkg::ST_RD_SIM;
            end
            shgs_pkg::KIND_SIM: begin
              sim_valid_d = 1'b1;
              state_d     = shgs_pkg::ST_LOAD_RD;
            end
            default: begin
              state_d = shgs_pkg::ST_LOAD_RD;
            end
          endcase
        end
      end
      shgs_pkg::ST_RD_SIM: begin
        sim_res_d = (sim_valid_q && lag_q != '0 && 32'(lag_q) < shgs_pkg::HIST_LEN)
                    ? sim_rdata_q : '0;
        state_d   = shgs_pkg::ST_OUT;
      end
      shgs_pkg::ST_LOAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = newest_q;
        state_d = shgs_pkg::ST_LOAD_WT;
      end
      shgs_pkg::ST_LOAD_WT: begin
        cur_d   = rok_q ? rdata_q : '0;
        band_d  = '0;
        suma_d  = '0;
        sumb_d  = '0;
        j_d     = JW'(1);
        state_d = (kind_q == shgs_pkg::KIND_GATE) ? shgs_pkg::ST_G_BAND : shgs_pkg::ST_S_LAG;
      end
      shgs_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          if (kind_q == shgs_pkg::KIND_READ) begin
            out_d            = '0;
            out_d.similarity = sim_res_q;
          end else begin
            out_d.band_out_0 = obands[0];
            out_d.band_out_1 = obands[1];
            out_d.band_out_2 = obands[2];
            out_d.band_out_3 = obands[3];
            out_d.band_out_4 = obands[4];
            out_d.band_out_5 = obands[5];
            out_d.band_out_6 = obands[6];
            out_d.band_out_7 = obands[7];
            out_d.similarity = '0;
          end
          out_valid_d = 1'b1;
          state_d     = shgs_pkg::ST_IDLE;
        end
      end

      shgs_pkg::ST_G_BAND: begin
        j_d   = '0;
        acc_d = '0;
        if (wbase_q && win != '0) begin
          state_d = shgs_pkg::ST_W_RD;
        end else begin
          av_d    = wbase_q ? '0 : cur_b;
          state_d = shgs_pkg::ST_F_INIT;
        end
      end
      shgs_pkg::ST_W_RD: begin
        rd_en   = 1'b1;
        state_d = shgs_pkg::ST_W_MUL;
      end
      shgs_pkg::ST_W_MUL: begin
        mul_a   = AW'(win - j_q);
        mul_b   = MW'(h_val);
        state_d = shgs_pkg::ST_W_ACC;
      end
      shgs_pkg::ST_W_ACC: begin
        acc_d = acc_q + prod_q[33:0];
        if (j_q == win - JW'(1)) begin
          state_d = shgs_pkg::ST_W_DEN;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = shgs_pkg::ST_W_RD;
        end
      end
      shgs_pkg::ST_W_DEN: begin
        mul_a   = AW'(win);
        mul_b   = MW'(win) + MW'(1);
        state_d = shgs_pkg::ST_W_DIV;
      end
      shgs_pkg::ST_W_DIV: begin
        div_req.start = 1'b1;
        div_req.den   = DW'(tri_w);
        div_req.num   = NW'(acc_q) + NW'(tri_w >> 1);
        state_d       = shgs_pkg::ST_W_WAIT;
      end
      shgs_pkg::ST_W_WAIT: begin
        if (div_rsp.done) begin
          av_d    = div_rsp.quot[VW-1:0];
          state_d = shgs_pkg::ST_F_INIT;
        end
      end
      shgs_pkg::ST_F_INIT: begin
        if (win == '0) begin
          fn_d    = 26'(av_q);
          state_d = shgs_pkg::ST_C_MUL;
        end else begin
          mul_a   = AW'(av_q);
          mul_b   = MW'(win);
          state_d = shgs_pkg::ST_F_SET;
        end
      end
      shgs_pkg::ST_F_SET: begin
        fn_d    = prod_q[25:0];
        j_d     = '0;
        state_d = shgs_pkg::ST_F_RD;
      end
      shgs_pkg::ST_F_RD: begin
        rd_en   = 1'b1;
        state_d = shgs_pkg::ST_F_M1;
      end
      shgs_pkg::ST_F_M1: begin
        mul_a   = AW'(win - j_q);
        mul_b   = MW'(h_val);
        state_d = shgs_pkg::ST_F_M2;
      end
      shgs_pkg::ST_F_M2: begin
        acc_d   = prod_q[33:0];
        mul_a   = AW'(j_q);
        mul_b   = MW'(av_q);
        state_d = shgs_pkg::ST_F_CMP;
      end
      shgs_pkg::ST_F_CMP: begin
        if (v_sum < fn_q) begin
          fn_d = v_sum;
        end
        if (j_q == win - JW'(1)) begin
          state_d = shgs_pkg::ST_C_MUL;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = shgs_pkg::ST_F_RD;
        end
      end
      shgs_pkg::ST_C_MUL: begin
        mul_a   = AW'(fn_q);
        mul_b   = MW'(scale_q);
        cd_d    = (win == '0) ? shgs_pkg::CD_W'(4096) : {win, 12'd0};
        state_d = shgs_pkg::ST_C_CUR;
      end
      shgs_pkg::ST_C_CUR: begin
        cn_d    = prod_q[41:0];
        mul_a   = AW'(cur_b);
        mul_b   = MW'(cd_q);
        state_d = shgs_pkg::ST_C_CMP;
      end
      shgs_pkg::ST_C_CMP: begin
        if (cn_q == '0) begin
          g_d[band_q] = cur_b;
          state_d     = shgs_pkg::ST_G_NEXT;
        end else if (43'(curcd) >= {cn_q, 1'b0}) begin
          div_req.start = 1'b1;
          div_req.den   = DW'(cd_q);
          div_req.num   = NW'(curcd) - NW'(cn_q) + NW'(cd_q >> 1);
          state_d       = shgs_pkg::ST_C_WAIT;
        end else begin
          g_d[band_q] = VW'((17'(cur_b) + 17'd1) >> 1);
          state_d     = shgs_pkg::ST_G_NEXT;
        end
      end
      shgs_pkg::ST_C_WAIT: begin
        if (div_rsp.done) begin
          g_d[band_q] = div_rsp.quot[VW-1:0];
          state_d     = shgs_pkg::ST_G_NEXT;
        end
      end
      shgs_pkg::ST_G_NEXT: begin
        suma_d = suma_q + 19'(g_b);
        sumb_d = sumb_q + 19'(cur_b);
        if (32'(band_q) == shgs_pkg::BANDS - 1) begin
          state_d = shgs_pkg::ST_L_CHK;
        end else begin
          band_d  = band_q + BW'(1);
          state_d = shgs_pkg::ST_G_BAND;
        end
      end
      shgs_pkg::ST_L_CHK: begin
        band_d  = '0;
        state_d = (restore_q && suma_q != '0) ? shgs_pkg::ST_L_BAND : shgs_pkg::ST_OUT;
      end
      shgs_pkg::ST_L_BAND: begin
        if (20'(sumb_q) >= {suma_q, 1'b0}) begin
          g_d[band_q] = shgs_pkg::sat16({1'b0, g_b, 1'b0});
          state_d     = shgs_pkg::ST_L_NEXT;
        end else begin
          mul_a   = AW'(g_b);
          mul_b   = MW'(sumb_q);
          state_d = shgs_pkg::ST_L_DIV;
        end
      end
      shgs_pkg::ST_L_DIV: begin
        div_req.start = 1'b1;
        div_req.den   = DW'(suma_q);
        div_req.num   = NW'(prod_q[34:0]) + NW'(suma_q >> 1);
        state_d       = shgs_pkg::ST_L_WAIT;
      end
      shgs_pkg::ST_L_WAIT: begin
        if (div_rsp.done) begin
          g_d[band_q] = shgs_pkg::sat16(18'(div_rsp.quot));
          state_d     = shgs_pkg::ST_L_NEXT;
        end
      end
      shgs_pkg::ST_L_NEXT: begin
        if (32'(band_q) == shgs_pkg::BANDS - 1) begin
          state_d = shgs_pkg::ST_OUT;
        end else begin
          band_d  = band_q + BW'(1);
          state_d = shgs_pkg::ST_L_BAND;
        end
      end

      shgs_pkg::ST_S_LAG: begin
        rd_en   = 1'b1;
        total_d = '0;
        band_d  = '0;
        state_d = shgs_pkg::ST_S_BAND;
      end
      shgs_pkg::ST_S_BAND: begin
        s_d  = f_sum;
        d_d  = f_dif;
        up_d = f_up;
        if (f_sum == '0) begin
          total_d = total_q + 21'(3 * 65536);
          state_d = shgs_pkg::ST_S_NEXT;
        end else begin
          state_d = shgs_pkg::ST_S_T1;
        end
      end
      shgs_pkg::ST_S_T1: begin
        den18         = 18'(s_q) + 18'(d_q);
        div_req.start = 1'b1;
        div_req.den   = DW'(den18);
        div_req.num   = (NW'(s_q) << 16) + NW'(den18 >> 1);
        state_d       = shgs_pkg::ST_S_W1;
      end
      shgs_pkg::ST_S_W1: begin
        if (div_rsp.done) begin
          total_d = total_q + 21'(div_rsp.quot);
          state_d = shgs_pkg::ST_S_T2;
        end
      end
      shgs_pkg::ST_S_T2: begin
        den18         = 18'(s_q) + 18'(up_q);
        div_req.start = 1'b1;
        div_req.den   = DW'(den18);
        div_req.num   = (NW'(s_q) << 16) + NW'(den18 >> 1);
        state_d       = shgs_pkg::ST_S_W2;
      end
      shgs_pkg::ST_S_W2: begin
        mul_a = AW'(s_q);
        mul_b = MW'(s_q);
        if (div_rsp.done) begin
          total_d = total_q + 21'(div_rsp.quot);
          state_d = shgs_pkg::ST_S_SQ;
        end
      end
      shgs_pkg::ST_S_SQ: begin
        sq_d    = {prod_q[33:0], 2'b00};
        mul_a   = AW'(d_q);
        mul_b   = MW'(d_q);
        state_d = shgs_pkg::ST_S_T3;
      end
      shgs_pkg::ST_S_T3: begin
        div_req.start = 1'b1;
        div_req.den   = DW'(den37);
        div_req.num   = (NW'(sq_q) << 16) + NW'(den37 >> 1);
        state_d       = shgs_pkg::ST_S_W3;
      end
      shgs_pkg::ST_S_W3: begin
        if (div_rsp.done) begin
          total_d = total_q + 21'(div_rsp.quot);
          state_d = shgs_pkg::ST_S_NEXT;
        end
      end
      shgs_pkg::ST_S_NEXT: begin
        if (32'(band_q) == shgs_pkg::BANDS - 1) begin
          state_d = shgs_pkg::ST_S_FIN;
        end else begin
          band_d  = band_q + BW'(1);
          state_d = shgs_pkg::ST_S_BAND;
        end
      end
      shgs_pkg::ST_S_FIN: begin
        // rounded mean of the terms by reciprocal multiply
        mul_a   = AW'(total_q + 21'(shgs_pkg::SIM_DIV / 2));
        mul_b   = MW'(shgs_pkg::SIM_RECIP);
        state_d = shgs_pkg::ST_S_WF;
      end
      shgs_pkg::ST_S_WF: begin
        sim_wr_en = 1'b1;
        if (32'(j_q) == shgs_pkg::HIST_LEN - 1) begin
          state_d = shgs_pkg::ST_IDLE;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = shgs_pkg::ST_S_LAG;
        end
      end
      default: begin
        state_d = shgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shgs_pkg::ST_IDLE;
      newest_q    <= '0;
      fill_q      <= '0;
      sim_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      fill_q      <= fill_d;
      sim_valid_q <= sim_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= 10'd30;
      scale_q   <= 16'd4096;
      wbase_q   <= 1'b0;
      restore_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        shgs_pkg::CFG_HISTORY_FRAMES:    hist_q    <= cfg_data_i[9:0];
        shgs_pkg::CFG_ROOT_SCALE:        scale_q   <= cfg_data_i;
        shgs_pkg::CFG_WEIGHTED_BASELINE: wbase_q   <= cfg_data_i[0];
        shgs_pkg::CFG_LOUDNESS_RESTORE:  restore_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    lag_q     <= lag_d;
    cur_q     <= cur_d;
    j_q       <= j_d;
    band_q    <= band_d;
    acc_q     <= acc_d;
    av_q      <= av_d;
    fn_q      <= fn_d;
    cn_q      <= cn_d;
    cd_q      <= cd_d;
    g_q       <= g_d;
    suma_q    <= suma_d;
    sumb_q    <= sumb_d;
    total_q   <= total_d;
    s_q       <= s_d;
    d_q       <= d_d;
    up_q      <= up_d;
    sq_q      <= sq_d;
    sim_res_q <= sim_res_d;
    out_q     <= out_d;
    prod_q    <= shgs_pkg::PROD_W'(mul_a) * shgs_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rdata_q <= frame_mem[rd_addr];
      rok_q   <= slot_ok(rd_addr, fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sim_wr_en) begin
      sim_mem[sim_wr_addr] <= sim_wr_data;
    end
    if (sim_rd_en) begin
      sim_rdata_q <= sim_mem[sim_rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= JW'(shgs_pkg::HIST_LEN))
    else $error("fill count beyond history depth");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == shgs_pkg::ST_W_WAIT || state_q == shgs_pkg::ST_C_WAIT ||
                      state_q == shgs_pkg::ST_L_WAIT || state_q == shgs_pkg::ST_S_W1 ||
                      state_q == shgs_pkg::ST_S_W2 || state_q == shgs_pkg::ST_S_W3))
    else $error("divider finished outside a wait state");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == shgs_pkg::ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

FILE: sv/shgs_divider.sv
// ----------------------------------------------------------------------------
// shgs_divider
// Restoring divider, one quotient bit per cycle, for quotients below 2^17.
// ----------------------------------------------------------------------------
module shgs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shgs_pkg::div_req_t req_i,
  output shgs_pkg::div_rsp_t rsp_o
);

  logic [shgs_pkg::NUM_W-1:0] rem_q, rem_d;
  logic [shgs_pkg::NUM_W-1:0] dsh_q, dsh_d;
  logic [shgs_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsh_d  = shgs_pkg::NUM_W'(req_i.den) << (shgs_pkg::QUO_W - 1);
      quo_d  = '0;
      cnt_d  = 5'(shgs_pkg::QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d = rem_q - dsh_q;
        quo_d = {quo_q[shgs_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[shgs_pkg::QUO_W-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule
